FILE: rtl/core/dgbf_pkg.sv
`timescale 1ns / 1ps

package dgbf_pkg;

   // Frame store geometry
   localparam int COORD_W     = 6;
   localparam int MAX_DIM     = 64;
   localparam int DIM_W       = 7;
   localparam int ADDR_W      = 2 * COORD_W;
   localparam int STORE_DEPTH = 1 << ADDR_W;
   localparam int TCOORD_W    = COORD_W + 2;

   // Pixel data
   localparam int CH_W     = 16;
   localparam int CHANNELS = 3;
   localparam int SCALE_W  = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;

   // Window
   localparam int RADIUS = 3;
   localparam int SPAN_W = $clog2(RADIUS + 1);
   localparam int DIST_W = 2 * SPAN_W + 1;

   // Exp table, 1.0 = 65536
   localparam int EXP_DEPTH     = 256;
   localparam int EXP_IDX_W     = $clog2(EXP_DEPTH);
   localparam int EXP_VAL_W     = 17;
   localparam int EXP_DECAY     = 61565;
   localparam int DIFF_SHIFT    = 20;
   localparam int SPATIAL_SHIFT = 4;

   // Shared multiplier
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Accumulators
   localparam int N_W    = 22;
   localparam int S_W    = 22;
   localparam int Q_W    = 40;
   localparam int PART_W = 18;
   localparam int VAR_W  = 32;

   // Divider
   localparam int DIV_W   = 56;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_FILTER = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_SPATIAL_SCALE = 3'd2,
      CSR_RANGE_SCALE   = 3'd3,
      CSR_DEPTH_SCALE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]   frame_width;
      logic [DIM_W-1:0]   frame_height;
      logic [SCALE_W-1:0] spatial_scale;
      logic [SCALE_W-1:0] range_scale;
      logic [SCALE_W-1:0] depth_scale;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0] depth;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } pixel_type;

   typedef enum logic [1:0] {
      GRP_AXIS_X,
      GRP_AXIS_Y,
      GRP_DIAG
   } group_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CTR_RD,
      ST_CTR_LATCH,
      ST_CTR_SQ,
      ST_CTR_ACC,
      ST_GRP_START,
      ST_GRP_WS,
      ST_NB_RD,
      ST_NB_D0,
      ST_NB_D1,
      ST_NB_D2,
      ST_C0,
      ST_C1,
      ST_C2,
      ST_C3,
      ST_C4,
      ST_C5,
      ST_C6,
      ST_C7,
      ST_C8,
      ST_GRP_SQ,
      ST_GRP_ACC,
      ST_DIV_M,
      ST_WAIT_M,
      ST_DIV_Q1,
      ST_WAIT_Q1,
      ST_DIV_Q2,
      ST_WAIT_Q2,
      ST_MM,
      ST_VAR,
      ST_RESP
   } state_type;

   typedef logic [EXP_VAL_W-1:0] exp_rom_type [EXP_DEPTH];

   // exp(-i/16) in Q1.16, each entry derived from the previous one
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [33:0] e;
      e = 34'd65536;
      for (int i = 0; i < EXP_DEPTH; i++) begin
         rom[i] = e[EXP_VAL_W-1:0];
         e = (e * 34'(EXP_DECAY) + 34'd32768) >> 16;
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

FILE: rtl/core/dgbf_frame_store.sv
`timescale 1ns / 1ps

module dgbf_frame_store import dgbf_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pixel_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output pixel_type         rd_data
);

   pixel_type mem [STORE_DEPTH];
   pixel_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dgbf_divider.sv
`timescale 1ns / 1ps

module dgbf_divider import dgbf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [N_W-1:0]   den,
   output logic             done,
   output logic [DIV_W-1:0] quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [N_W-1:0]       rem_ff, rem_in;
   logic [N_W-1:0]       den_ff, den_in;
   logic [N_W:0]         trial;
   logic [N_W:0]         diff;
   logic                 ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[N_W-1:0] : trial[N_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

FILE: rtl/core/dgbf_engine.sv
`timescale 1ns / 1ps

module dgbf_engine import dgbf_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [COORD_W-1:0]                pos_x,
   input  logic [COORD_W-1:0]                pos_y,
   input  cfg_type                           cfg,
   output logic                              rd_en,
   output logic [ADDR_W-1:0]                 rd_addr,
   input  pixel_type                         rd_data,
   output logic                              idle,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [CHANNELS-1:0][CH_W-1:0]     mean,
   output logic [CHANNELS-1:0][VAR_W-1:0]    var_est
);

   state_type                         state_ff, state_in;
   logic [1:0]                        ch_ff, ch_in;
   logic [1:0]                        k_ff, k_in;
   logic [SPAN_W-1:0]                 a_ff, a_in;
   logic [SPAN_W-1:0]                 b_ff, b_in;
   group_type                         kind_ff, kind_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic [COORD_W-1:0]                x_ff, x_in;
   logic [COORD_W-1:0]                y_ff, y_in;
   pixel_type                         ctr_ff, ctr_in;
   logic [EXP_VAL_W-1:0]              ws_ff, ws_in;
   logic [EXP_VAL_W-1:0]              wd_ff, wd_in;
   logic [EXP_VAL_W-1:0]              wr_ff, wr_in;
   logic [EXP_VAL_W-1:0]              w_ff, w_in;
   logic [CHANNELS-1:0][N_W-1:0]      acc_n_ff, acc_n_in;
   logic [CHANNELS-1:0][S_W-1:0]      acc_s_ff, acc_s_in;
   logic [CHANNELS-1:0][Q_W-1:0]      acc_q_ff, acc_q_in;
   logic [CHANNELS-1:0][PART_W-1:0]   part_ff, part_in;
   logic [CH_W-1:0]                   m_ff, m_in;
   logic [Q_W-1:0]                    qv_ff, qv_in;
   logic [CHANNELS-1:0][CH_W-1:0]     mean_ff, mean_in;
   logic [CHANNELS-1:0][VAR_W-1:0]    var_ff, var_in;
   logic [MUL_P_W-1:0]                mul_ff;

   logic [MUL_A_W-1:0]                mul_a;
   logic [MUL_B_W-1:0]                mul_b;
   logic                              div_start;
   logic [DIV_W-1:0]                  div_num;
   logic                              div_done;
   logic [DIV_W-1:0]                  div_quot;

   logic                              sign_x, sign_y, last_member;
   logic [TCOORD_W-1:0]               ax, by, tx, ty;
   logic [COORD_W-1:0]                cx, cy;
   logic [DIST_W-1:0]                 dist2;
   logic [CH_W-1:0]                   diff;
   logic [EXP_VAL_W-1:0]              rnd;

   function automatic logic [DIM_W-1:0] dim_hi(input logic [DIM_W-1:0] lim);
      if (lim == '0) begin
         return '0;
      end else if (lim > DIM_W'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM - 1);
      end else begin
         return lim - 1'b1;
      end
   endfunction

   function automatic logic [COORD_W-1:0] clamp(input logic [TCOORD_W-1:0] t,
                                                input logic [DIM_W-1:0] hi);
      if (t[TCOORD_W-1]) begin
         return '0;
      end else if (t > TCOORD_W'(hi)) begin
         return hi[COORD_W-1:0];
      end else begin
         return t[COORD_W-1:0];
      end
   endfunction

   function automatic logic [CH_W-1:0] chan_sel(input pixel_type p, input logic [1:0] c);
      case (c)
         2'd0:    return p.red;
         2'd1:    return p.green;
         default: return p.blue;
      endcase
   endfunction

   function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] p,
                                                input logic [CH_W-1:0] q);
      return (p > q) ? (p - q) : (q - p);
   endfunction

   function automatic logic [EXP_VAL_W-1:0] rom_diff(input logic [MUL_P_W-1:0] p);
      if (p[MUL_P_W-1:DIFF_SHIFT+EXP_IDX_W] != '0) begin
         return '0;
      end else begin
         return EXP_ROM[p[DIFF_SHIFT+EXP_IDX_W-1:DIFF_SHIFT]];
      end
   endfunction

   function automatic logic [EXP_VAL_W-1:0] rom_spatial(input logic [MUL_P_W-1:0] p);
      if (p[MUL_P_W-1:SPATIAL_SHIFT+EXP_IDX_W] != '0) begin
         return '0;
      end else begin
         return EXP_ROM[p[SPATIAL_SHIFT+EXP_IDX_W-1:SPATIAL_SHIFT]];
      end
   endfunction

   function automatic logic [VAR_W-1:0] sat_var(input logic [Q_W-1:0] q,
                                                input logic [2*CH_W-1:0] mm);
      logic [Q_W+1:0] d;
      d = {2'b00, q} - (Q_W+2)'(mm);
      if (d[Q_W+1] == 1'b0 && d[Q_W:VAR_W-1] != '0) begin
         return {1'b0, {(VAR_W-1){1'b1}}};
      end else if (d[Q_W+1] == 1'b1 && d[Q_W:VAR_W-1] != '1) begin
         return {1'b1, {(VAR_W-1){1'b0}}};
      end else begin
         return d[VAR_W-1:0];
      end
   endfunction

   // neighbor offset and clamped store address
   always_comb begin
      sign_x      = (kind_ff == GRP_DIAG) ? k_ff[1] : k_ff[0];
      sign_y      = k_ff[0];
      last_member = (kind_ff == GRP_DIAG) ? (k_ff == 2'd3) : (k_ff == 2'd1);
      ax          = TCOORD_W'(a_ff);
      by          = TCOORD_W'(b_ff);
      tx          = TCOORD_W'(x_ff) + (sign_x ? ax : (~ax + 1'b1));
      ty          = TCOORD_W'(y_ff) + (sign_y ? by : (~by + 1'b1));
      cx          = clamp(tx, dim_hi(cfg.frame_width));
      cy          = clamp(ty, dim_hi(cfg.frame_height));
      rd_addr     = {cy, cx};
      dist2       = DIST_W'(a_ff) * DIST_W'(a_ff) + DIST_W'(b_ff) * DIST_W'(b_ff);
      rnd         = EXP_VAL_W'((mul_ff[33:0] + 34'd32768) >> 16);
   end

   // sequencer: next state, datapath register loads, shared multiplier operands
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ctr_in       = ctr_ff;
      ws_in        = ws_ff;
      wd_in        = wd_ff;
      wr_in        = wr_ff;
      w_in         = w_ff;
      acc_n_in     = acc_n_ff;
      acc_s_in     = acc_s_ff;
      acc_q_in     = acc_q_ff;
      part_in      = part_ff;
      m_in         = m_ff;
      qv_in        = qv_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      mul_a        = '0;
      mul_b        = '0;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      div_num      = '0;
      diff         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = pos_x;
               y_in     = pos_y;
               a_in     = '0;
               b_in     = '0;
               k_in     = '0;
               kind_in  = GRP_AXIS_X;
               state_in = ST_CTR_RD;
            end
         end
         ST_CTR_RD: begin
            rd_en    = 1'b1;
            state_in = ST_CTR_LATCH;
         end
         ST_CTR_LATCH: begin
            ctr_in   = rd_data;
            ch_in    = '0;
            state_in = ST_CTR_SQ;
         end
         ST_CTR_SQ: begin
            mul_a    = MUL_A_W'(chan_sel(ctr_ff, ch_ff));
            mul_b    = MUL_B_W'(chan_sel(ctr_ff, ch_ff));
            state_in = ST_CTR_ACC;
         end
         ST_CTR_ACC: begin
            acc_n_in[ch_ff] = N_W'(32'd65536);
            acc_s_in[ch_ff] = S_W'(chan_sel(ctr_ff, ch_ff));
            acc_q_in[ch_ff] = Q_W'(mul_ff[2*CH_W-1:0]);
            if (ch_ff == 2'd2) begin
               a_in     = SPAN_W'(1);
               b_in     = '0;
               kind_in  = GRP_AXIS_X;
               k_in     = '0;
               state_in = ST_GRP_START;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_CTR_SQ;
            end
         end
         ST_GRP_START: begin
            mul_a    = MUL_A_W'(cfg.spatial_scale);
            mul_b    = MUL_B_W'(dist2);
            part_in  = '0;
            state_in = ST_GRP_WS;
         end
         ST_GRP_WS: begin
            ws_in    = rom_spatial(mul_ff);
            state_in = ST_NB_RD;
         end
         ST_NB_RD: begin
            rd_en    = 1'b1;
            state_in = ST_NB_D0;
         end
         // depth kernel
         ST_NB_D0: begin
            diff     = abs_diff(rd_data.depth, ctr_ff.depth);
            mul_a    = MUL_A_W'(diff);
            mul_b    = MUL_B_W'(diff);
            state_in = ST_NB_D1;
         end
         ST_NB_D1: begin
            mul_a    = mul_ff[MUL_A_W-1:0];
            mul_b    = MUL_B_W'(cfg.depth_scale);
            state_in = ST_NB_D2;
         end
         ST_NB_D2: begin
            wd_in    = rom_diff(mul_ff);
            ch_in    = '0;
            state_in = ST_C0;
         end
         // per-channel color kernel, weight and term
         ST_C0: begin
            diff     = abs_diff(chan_sel(rd_data, ch_ff), chan_sel(ctr_ff, ch_ff));
            mul_a    = MUL_A_W'(diff);
            mul_b    = MUL_B_W'(diff);
            state_in = ST_C1;
         end
         ST_C1: begin
            mul_a    = mul_ff[MUL_A_W-1:0];
            mul_b    = MUL_B_W'(cfg.range_scale);
            state_in = ST_C2;
         end
         ST_C2: begin
            wr_in    = rom_diff(mul_ff);
            state_in = ST_C3;
         end
         ST_C3: begin
            mul_a    = MUL_A_W'(ws_ff);
            mul_b    = MUL_B_W'(wr_ff);
            state_in = ST_C4;
         end
         ST_C4: begin
            w_in     = rnd;
            state_in = ST_C5;
         end
         ST_C5: begin
            mul_a    = MUL_A_W'(w_ff);
            mul_b    = MUL_B_W'(wd_ff);
            state_in = ST_C6;
         end
         ST_C6: begin
            w_in            = rnd;
            acc_n_in[ch_ff] = acc_n_ff[ch_ff] + N_W'(rnd);
            state_in        = ST_C7;
         end
         ST_C7: begin
            mul_a    = MUL_A_W'(w_ff);
            mul_b    = MUL_B_W'(chan_sel(rd_data, ch_ff));
            state_in = ST_C8;
         end
         ST_C8: begin
            part_in[ch_ff] = part_ff[ch_ff] + PART_W'(rnd);
            if (ch_ff != 2'd2) begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_C0;
            end else if (!last_member) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_NB_RD;
            end else begin
               ch_in    = '0;
               state_in = ST_GRP_SQ;
            end
         end
         // fold group partial sums
         ST_GRP_SQ: begin
            mul_a    = MUL_A_W'(part_ff[ch_ff]);
            mul_b    = MUL_B_W'(part_ff[ch_ff]);
            state_in = ST_GRP_ACC;
         end
         ST_GRP_ACC: begin
            acc_s_in[ch_ff] = acc_s_ff[ch_ff] + S_W'(part_ff[ch_ff]);
            acc_q_in[ch_ff] = acc_q_ff[ch_ff] + Q_W'(mul_ff[2*PART_W-1:0]);
            if (ch_ff != 2'd2) begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_GRP_SQ;
            end else begin
               ch_in    = '0;
               k_in     = '0;
               state_in = ST_GRP_START;
               case (kind_ff)
                  GRP_AXIS_X: begin
                     if (a_ff == SPAN_W'(RADIUS)) begin
                        kind_in = GRP_AXIS_Y;
                        a_in    = '0;
                        b_in    = SPAN_W'(1);
                     end else begin
                        a_in = a_ff + 1'b1;
                     end
                  end
                  GRP_AXIS_Y: begin
                     if (b_ff == SPAN_W'(RADIUS)) begin
                        kind_in = GRP_DIAG;
                        a_in    = SPAN_W'(1);
                        b_in    = SPAN_W'(1);
                     end else begin
                        b_in = b_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (a_ff != SPAN_W'(RADIUS)) begin
                        a_in = a_ff + 1'b1;
                     end else if (b_ff != SPAN_W'(RADIUS)) begin
                        a_in = SPAN_W'(1);
                        b_in = b_ff + 1'b1;
                     end else begin
                        state_in = ST_DIV_M;
                     end
                  end
               endcase
            end
         end
         // mean = ((S << 16) + N/2) / N
         ST_DIV_M: begin
            div_start = 1'b1;
            div_num   = DIV_W'({acc_s_ff[ch_ff], 16'b0}) + DIV_W'(acc_n_ff[ch_ff] >> 1);
            state_in  = ST_WAIT_M;
         end
         ST_WAIT_M: begin
            if (div_done) begin
               m_in     = (div_quot[DIV_W-1:CH_W] != '0) ? '1 : div_quot[CH_W-1:0];
               state_in = ST_DIV_Q1;
            end
         end
         // second moment, two truncating divisions
         ST_DIV_Q1: begin
            div_start = 1'b1;
            div_num   = DIV_W'({acc_q_ff[ch_ff], 16'b0});
            state_in  = ST_WAIT_Q1;
         end
         ST_WAIT_Q1: begin
            if (div_done) begin
               qv_in    = div_quot[Q_W-1:0];
               state_in = ST_DIV_Q2;
            end
         end
         ST_DIV_Q2: begin
            div_start = 1'b1;
            div_num   = DIV_W'({qv_ff, 16'b0});
            state_in  = ST_WAIT_Q2;
         end
         ST_WAIT_Q2: begin
            if (div_done) begin
               qv_in    = div_quot[Q_W-1:0];
               state_in = ST_MM;
            end
         end
         ST_MM: begin
            mul_a    = MUL_A_W'(m_ff);
            mul_b    = MUL_B_W'(m_ff);
            state_in = ST_VAR;
         end
         ST_VAR: begin
            mean_in[ch_ff] = m_ff;
            var_in[ch_ff]  = sat_var(qv_ff, mul_ff[2*CH_W-1:0]);
            if (ch_ff == 2'd2) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_RESP;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_DIV_M;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         k_ff         <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         kind_ff      <= GRP_AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         k_ff         <= k_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers and shared multiplier
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      ctr_ff   <= ctr_in;
      ws_ff    <= ws_in;
      wd_ff    <= wd_in;
      wr_ff    <= wr_in;
      w_ff     <= w_in;
      acc_n_ff <= acc_n_in;
      acc_s_ff <= acc_s_in;
      acc_q_ff <= acc_q_in;
      part_ff  <= part_in;
      m_ff     <= m_in;
      qv_ff    <= qv_in;
      mean_ff  <= mean_in;
      var_ff   <= var_in;
      mul_ff   <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

   dgbf_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (acc_n_ff[ch_ff]),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign idle      = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign mean      = mean_ff;
   assign var_est   = var_ff;

endmodule

FILE: rtl/core/depth_guided_bilateral_filter_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   action, pos_x, pos_y, red/green/blue/depth_in
// rsp       out        rsp_valid / rsp_stall   mean_red/green/blue, var_red/green/blue
// csr       in         csr_wr_en               csr_index, csr_wdata
//
// A load transaction is written to the frame store at accept.
// A filter transaction runs from accept to response through 48 neighbors, each a
// sequence of states on the one shared 32x18 multiplier, plus nine divisions in the
// serial divider.
// req_stall is high from a filter accept until its response is taken.
// Reset is synchronous; the frame store is not cleared and holds no valid bits.
// A stalled response holds its payload; no new transaction is taken meanwhile.

module depth_guided_bilateral_filter_unit import dgbf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic [COORD_W-1:0]      req_pos_x,
   input  logic [COORD_W-1:0]      req_pos_y,
   input  logic [CH_W-1:0]         req_red_in,
   input  logic [CH_W-1:0]         req_green_in,
   input  logic [CH_W-1:0]         req_blue_in,
   input  logic [CH_W-1:0]         req_depth_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [CH_W-1:0]         rsp_mean_red,
   output logic [CH_W-1:0]         rsp_mean_green,
   output logic [CH_W-1:0]         rsp_mean_blue,
   output logic signed [VAR_W-1:0] rsp_var_red,
   output logic signed [VAR_W-1:0] rsp_var_green,
   output logic signed [VAR_W-1:0] rsp_var_blue,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   cfg_type                        cfg_ff, cfg_in;
   logic                           idle;
   logic                           req_accept;
   logic                           store_wr_en;
   logic                           filter_start;
   pixel_type                      wr_pixel;
   logic                           rd_en;
   logic [ADDR_W-1:0]              rd_addr;
   pixel_type                      rd_data;
   logic [CHANNELS-1:0][CH_W-1:0]  mean;
   logic [CHANNELS-1:0][VAR_W-1:0] var_est;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_wdata[DIM_W-1:0];
            CSR_SPATIAL_SCALE: cfg_in.spatial_scale = csr_wdata[SCALE_W-1:0];
            CSR_RANGE_SCALE:   cfg_in.range_scale   = csr_wdata[SCALE_W-1:0];
            CSR_DEPTH_SCALE:   cfg_in.depth_scale   = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= DIM_W'(MAX_DIM);
         cfg_ff.frame_height  <= DIM_W'(MAX_DIM);
         cfg_ff.spatial_scale <= SCALE_W'(128);
         cfg_ff.range_scale   <= SCALE_W'(128);
         cfg_ff.depth_scale   <= SCALE_W'(128);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request decode: loads go straight to the store, filters start the engine
   always_comb begin
      req_stall      = ~idle;
      req_accept     = req_valid & ~req_stall;
      store_wr_en    = req_accept & (action_type'(req_action) == ACT_LOAD);
      filter_start   = req_accept & (action_type'(req_action) == ACT_FILTER);
      wr_pixel.red   = req_red_in;
      wr_pixel.green = req_green_in;
      wr_pixel.blue  = req_blue_in;
      wr_pixel.depth = req_depth_in;
   end

   dgbf_frame_store u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr ({req_pos_y, req_pos_x}),
      .wr_data (wr_pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dgbf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (filter_start),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .cfg       (cfg_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .idle      (idle),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .mean      (mean),
      .var_est   (var_est)
   );

   assign rsp_mean_red   = mean[0];
   assign rsp_mean_green = mean[1];
   assign rsp_mean_blue  = mean[2];
   assign rsp_var_red    = var_est[0];
   assign rsp_var_green  = var_est[1];
   assign rsp_var_blue   = var_est[2];

endmodule

FILE: tb/depth_guided_bilateral_filter_unit_tb.sv
`timescale 1ns / 1ps

module depth_guided_bilateral_filter_unit_tb;
   import dgbf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int LONG_HOLD_CYCLES = 5000;

   typedef struct {
      logic [CH_W-1:0]  mean_ch [CHANNELS];
      logic [VAR_W-1:0] dev_ch [CHANNELS];
   } filter_result_t;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_action;
   logic [COORD_W-1:0]      req_pos_x;
   logic [COORD_W-1:0]      req_pos_y;
   logic [CH_W-1:0]         req_red_in;
   logic [CH_W-1:0]         req_green_in;
   logic [CH_W-1:0]         req_blue_in;
   logic [CH_W-1:0]         req_depth_in;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [CH_W-1:0]         rsp_mean_red;
   logic [CH_W-1:0]         rsp_mean_green;
   logic [CH_W-1:0]         rsp_mean_blue;
   logic signed [VAR_W-1:0] rsp_var_red;
   logic signed [VAR_W-1:0] rsp_var_green;
   logic signed [VAR_W-1:0] rsp_var_blue;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_W-1:0]        csr_wdata;

   depth_guided_bilateral_filter_unit u_top (.*);

   // Shadow state of the block
   pixel_type      frame_mem [STORE_DEPTH];
   bit             pixel_loaded [STORE_DEPTH];
   int unsigned    exp_table [EXP_DEPTH];
   int unsigned    width_reg, height_reg;
   int unsigned    spatial_reg, range_reg, depth_reg;
   filter_result_t pending_filters [$];

   int  fail_count;
   bit  no_idle;
   bit  hold_request;
   int  base_level;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   initial begin
      #60_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic void build_exp_table();
      longint unsigned e;
      e = 65536;
      for (int i = 0; i < EXP_DEPTH; i++) begin
         exp_table[i] = int'(e);
         e = (e * EXP_DECAY + 32768) >> 16;
      end
   endfunction

   function automatic longint unsigned exp_weight(longint unsigned idx);
      return idx < EXP_DEPTH ? exp_table[idx] : 0;
   endfunction

   function automatic longint unsigned diff_weight(longint unsigned a, longint unsigned b,
                                                    longint unsigned scale);
      longint unsigned d;
      d = a > b ? a - b : b - a;
      return exp_weight((d * d * scale) >> DIFF_SHIFT);
   endfunction

   function automatic longint unsigned round_mul(longint unsigned a, longint unsigned b);
      return (a * b + 32768) >> 16;
   endfunction

   // Out-of-range frame sizes: 0 acts as 1, above the maximum acts as the maximum
   function automatic int clamp_coord(int c, int unsigned lim);
      int hi;
      hi = (lim == 0 ? 1 : (lim > MAX_DIM ? MAX_DIM : lim)) - 1;
      if (c < 0) return 0;
      if (c > hi) return hi;
      return c;
   endfunction

   function automatic int window_addr(int x, int y);
      return clamp_coord(y, height_reg) * MAX_DIM + clamp_coord(x, width_reg);
   endfunction

   function automatic longint unsigned channel_of(pixel_type p, int c);
      case (c)
         0: return p.red;
         1: return p.green;
         default: return p.blue;
      endcase
   endfunction

   // Filter only where every clamped window pixel has been loaded
   function automatic bit window_loaded(int x, int y);
      for (int dy = -RADIUS; dy <= RADIUS; dy++)
         for (int dx = -RADIUS; dx <= RADIUS; dx++)
            if (!pixel_loaded[window_addr(x + dx, y + dy)]) return 0;
      return 1;
   endfunction

   // Joint bilateral mean and variance for one target pixel
   function automatic filter_result_t bilateral_at(int x, int y);
      filter_result_t  res;
      pixel_type       ctr, nb;
      longint unsigned wsum [CHANNELS], vsum [CHANNELS], sqsum [CHANNELS];
      longint unsigned part [CHANNELS];
      longint unsigned ws, wd, w, ch, m, q;
      longint          dev;
      int              gdx [4], gdy [4];
      int              cnt, u, v, dist_sq;
      ctr = frame_mem[window_addr(x, y)];
      for (int c = 0; c < CHANNELS; c++) begin
         wsum[c] = 65536;
         vsum[c] = channel_of(ctr, c);
         sqsum[c] = vsum[c] * vsum[c];
      end
      for (int g = 0; g < 15; g++) begin
         if (g < 3) begin
            u = g + 1;
            cnt = 2; dist_sq = u * u;
            gdx[0] = -u; gdy[0] = 0; gdx[1] = u; gdy[1] = 0;
         end else if (g < 6) begin
            v = g - 2;
            cnt = 2; dist_sq = v * v;
            gdx[0] = 0; gdy[0] = -v; gdx[1] = 0; gdy[1] = v;
         end else begin
            v = (g - 6) / 3 + 1;
            u = (g - 6) % 3 + 1;
            cnt = 4; dist_sq = u * u + v * v;
            gdx[0] = -u; gdy[0] = -v; gdx[1] = -u; gdy[1] = v;
            gdx[2] = u;  gdy[2] = -v; gdx[3] = u;  gdy[3] = v;
         end
         ws = exp_weight((longint'(spatial_reg) * dist_sq) >> SPATIAL_SHIFT);
         for (int c = 0; c < CHANNELS; c++) part[c] = 0;
         for (int k = 0; k < cnt; k++) begin
            nb = frame_mem[window_addr(x + gdx[k], y + gdy[k])];
            wd = diff_weight(nb.depth, ctr.depth, depth_reg);
            for (int c = 0; c < CHANNELS; c++) begin
               ch = channel_of(nb, c);
               w = round_mul(ws, diff_weight(ch, channel_of(ctr, c), range_reg));
               w = round_mul(w, wd);
               wsum[c] += w;
               part[c] += round_mul(w, ch);
            end
         end
         for (int c = 0; c < CHANNELS; c++) begin
            vsum[c] += part[c];
            sqsum[c] += part[c] * part[c];
         end
      end
      for (int c = 0; c < CHANNELS; c++) begin
         m = ((vsum[c] << 16) + wsum[c] / 2) / wsum[c];
         if (m > 65535) m = 65535;
         q = ((sqsum[c] << 16) / wsum[c] << 16) / wsum[c];
         dev = longint'(q) - longint'(m * m);
         if (dev > 64'sd2147483647) dev = 64'sd2147483647;
         if (dev < -64'sd2147483648) dev = -64'sd2147483648;
         res.mean_ch[c] = m[CH_W-1:0];
         res.dev_ch[c] = dev[VAR_W-1:0];
      end
      return res;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 200);
   endfunction

   // Send one transaction; valid stays high for a back-to-back follower
   task automatic send_item(action_type act, int x, int y, logic [CH_W-1:0] r,
                            logic [CH_W-1:0] g, logic [CH_W-1:0] b, logic [CH_W-1:0] d);
      int gap;
      req_valid    <= 1'b1;
      req_action   <= act;
      req_pos_x    <= COORD_W'(x);
      req_pos_y    <= COORD_W'(y);
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      req_depth_in <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act == ACT_LOAD) begin
         frame_mem[y * MAX_DIM + x] = '{depth: d, blue: b, green: g, red: r};
         pixel_loaded[y * MAX_DIM + x] = 1'b1;
      end else begin
         pending_filters.push_back(bilateral_at(x, y));
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait for the block to drain before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_filters.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_regs(int unsigned fw, int unsigned fh, int unsigned ss,
                               int unsigned rs, int unsigned ds);
      logic [CSR_W-1:0] vals [5];
      vals[0] = CSR_W'(fw) | CSR_W'($urandom << DIM_W);
      vals[1] = CSR_W'(fh) | CSR_W'($urandom << DIM_W);
      vals[2] = CSR_W'(ss);
      vals[3] = CSR_W'(rs);
      vals[4] = CSR_W'(ds);
      settle();
      csr_wr_en <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      // Unmapped index must leave everything alone
      csr_index <= CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI));
      csr_wdata <= CSR_W'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      width_reg   = vals[0][DIM_W-1:0];
      height_reg  = vals[1][DIM_W-1:0];
      spatial_reg = vals[2];
      range_reg   = vals[3];
      depth_reg   = vals[4];
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [CH_W-1:0] pixel_value();
      if ($urandom_range(0, 9) < 8) return CH_W'(base_level + $urandom_range(0, 2047));
      return CH_W'($urandom);
   endfunction

   function automatic int unsigned pick_scale();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 16'hFFFF;
         2, 3: return $urandom_range(1, 512);
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   function automatic int unsigned pick_dim();
      case ($urandom_range(0, 7))
         0: return 1;
         1: return MAX_DIM;
         2: return 0;
         3: return $urandom_range(MAX_DIM + 1, 127);
         default: return $urandom_range(2, 20);
      endcase
   endfunction

   // Random mix: loads mostly into a corner block, filters where the window is loaded
   task automatic random_traffic(int count);
      int  x, y;
      bit  picked;
      for (int i = 0; i < count; i++) begin
         picked = 0;
         if ($urandom_range(0, 9) == 0) begin
            for (int t = 0; t < 8 && !picked; t++) begin
               if ($urandom_range(0, 3) == 0) begin
                  x = $urandom_range(0, 63);
                  y = $urandom_range(0, 63);
               end else begin
                  x = $urandom_range(0, 18);
                  y = $urandom_range(0, 18);
               end
               picked = window_loaded(x, y);
            end
         end
         if (picked) begin
            send_item(ACT_FILTER, x, y, CH_W'($urandom), CH_W'($urandom),
                      CH_W'($urandom), CH_W'($urandom));
         end else begin
            if ($urandom_range(0, 9) < 7) begin
               x = $urandom_range(0, 15);
               y = $urandom_range(0, 15);
            end else begin
               x = $urandom_range(0, 63);
               y = $urandom_range(0, 63);
            end
            send_item(ACT_LOAD, x, y, pixel_value(), pixel_value(), pixel_value(),
                      pixel_value());
         end
      end
   endtask

   // Corner block with extreme values, then filters across edge and size cases
   task automatic test_directed();
      logic [CH_W-1:0] r, g, b, d;
      for (int i = 0; i < 16; i++) begin
         r = (i % 3 == 0) ? 16'hFFFF : 16'hFFFF - CH_W'(i * 40);
         g = (i % 4 == 0) ? 16'h0000 : CH_W'(i * 37);
         b = 16'h8000 + CH_W'($urandom_range(0, 900));
         d = (i < 8) ? 16'h0000 : 16'hFFFF;
         send_item(ACT_LOAD, i % 4, i / 4, r, g, b, d);
      end
      // reset configuration, window clamps into the loaded block
      send_item(ACT_FILTER, 0, 0, '0, '0, '0, '0);
      program_regs(4, 4, 128, 128, 128);
      send_item(ACT_FILTER, 3, 3, '1, '1, '1, '1);
      send_item(ACT_FILTER, 63, 63, '0, '0, '0, '0);
      program_regs(0, 0, 128, 128, 128);
      send_item(ACT_FILTER, 40, 7, '0, '0, '0, '0);
      program_regs(127, 127, 128, 128, 128);
      send_item(ACT_FILTER, 0, 0, '0, '0, '0, '0);
      program_regs(4, 4, 0, 0, 0);
      send_item(ACT_FILTER, 2, 1, '0, '0, '0, '0);
      program_regs(4, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(ACT_FILTER, 1, 2, '0, '0, '0, '0);
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 5; p++) begin
         base_level = $urandom_range(0, 16'hF7FF);
         program_regs(pick_dim(), pick_dim(), pick_scale(), pick_scale(), pick_scale());
         no_idle = (p == 2);
         random_traffic(360);
         no_idle = 1'b0;
      end
   endtask

   // Receiver holds off long while the sender keeps offering
   task automatic test_backpressure();
      program_regs(8, 8, 128, 256, 128);
      hold_request = 1'b1;
      random_traffic(80);
   endtask

   // Receiver stall pattern
   initial begin
      rsp_stall = 1'b0;
      hold_request = 1'b0;
      forever begin
         int len;
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            len = pick_gap();
            if (len > 0) begin
               rsp_stall <= 1'b1;
               repeat (len) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Response checker
   always @(posedge clock) begin
      filter_result_t exp_res, got;
      string names [6];
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_filters.size() == 0) begin
            $error("response with no filter transaction outstanding");
            fail_count++;
         end else begin
            names = '{"mean_red", "mean_green", "mean_blue", "var_red", "var_green",
                      "var_blue"};
            exp_res = pending_filters.pop_front();
            got.mean_ch = '{rsp_mean_red, rsp_mean_green, rsp_mean_blue};
            got.dev_ch  = '{rsp_var_red, rsp_var_green, rsp_var_blue};
            for (int c = 0; c < CHANNELS; c++) begin
               if (got.mean_ch[c] !== exp_res.mean_ch[c]) begin
                  $error("%s: expected %0d, got %0d", names[c], exp_res.mean_ch[c],
                         got.mean_ch[c]);
                  fail_count++;
               end
               if (got.dev_ch[c] !== exp_res.dev_ch[c]) begin
                  $error("%s: expected %0d, got %0d", names[3 + c],
                         $signed(exp_res.dev_ch[c]), $signed(got.dev_ch[c]));
                  fail_count++;
               end
            end
         end
      end
   end

   // Main sequence
   initial begin
      int waited;
      fail_count   = 0;
      no_idle      = 1'b0;
      base_level   = 16'h4000;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_action   = ACT_LOAD;
      req_pos_x    = '0;
      req_pos_y    = '0;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      req_depth_in = '0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_FRAME_WIDTH;
      csr_wdata    = '0;
      width_reg    = 64;
      height_reg   = 64;
      spatial_reg  = 128;
      range_reg    = 128;
      depth_reg    = 128;
      build_exp_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phases();
      test_backpressure();

      req_valid <= 1'b0;
      waited = 0;
      while (pending_filters.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_filters.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
